// ===== hdl/assert_macros.svh =====
// Assertion macros used by the top-level RTL file of the blank trimmer.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked on every rising edge of i_clk, off while reset is held.
`define SBST_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// Plain invariant checked on every rising edge of i_clk, off while reset is held.
`define SBST_ASSERT_ALWAYS(label, expr, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (expr)) else $error(msg);

`endif

// ===== hdl/sbst_pkg.sv =====
// Package: code point constants, character classes, types for the blank trimmer.
`timescale 1ns / 1ps

package sbst_pkg;

    localparam int CP_W = 21;

    localparam logic [CP_W-1:0] CP_TAB   = 21'h00009;
    localparam logic [CP_W-1:0] CP_LF    = 21'h0000A;
    localparam logic [CP_W-1:0] CP_CR    = 21'h0000D;
    localparam logic [CP_W-1:0] CP_SPACE = 21'h00020;
    localparam logic [CP_W-1:0] CP_NEL   = 21'h00085;
    localparam logic [CP_W-1:0] CP_LS    = 21'h02028;
    localparam logic [CP_W-1:0] CP_PS    = 21'h02029;
    localparam logic [CP_W-1:0] CP_NONE  = 21'h00000;

    // held blank kind: 0 = space, 1 = tab
    localparam logic KIND_SPACE = 1'b0;
    localparam logic KIND_TAB   = 1'b1;

    typedef enum logic [2:0] {
        S_IDLE  = 3'b001,
        S_DRAIN = 3'b010,
        S_TAIL  = 3'b100
    } t_state;

    // control from the sequencer to every buffer cell
    typedef struct packed {
        logic push;   // write the cell whose index equals the fill count
        logic shift;  // every cell takes its upper neighbor's kind
        logic kind;   // kind written on push
    } t_cell_ctl;

    function automatic logic is_break_cp(input logic [CP_W-1:0] cp);
        return (cp == CP_LF) || (cp == CP_CR) || (cp == CP_NEL) ||
               (cp == CP_LS) || (cp == CP_PS);
    endfunction

    function automatic logic is_blank_cp(input logic [CP_W-1:0] cp);
        return (cp == CP_SPACE) || (cp == CP_TAB);
    endfunction

endpackage

// ===== hdl/segment_break_space_trimmer.sv =====
// Top level: segment break blank trimmer, sequencer plus a chain of blank cells.
`timescale 1ns / 1ps
//
//  channel  direction  handshake                 payload
//  -------  ---------  ------------------------  ----------------------------------------
//  in       sink       i_in_valid / o_in_stall   i_code_point, i_end_of_text
//  out      source     o_out_valid / i_out_stall o_out_code_point, o_char_valid,
//                                                o_last_of_run, o_text_done,
//                                                o_blank_overflow
//
//  An input beat is taken while the sequencer is idle. A blank that produces
//  nothing leaves the block ready again on the next cycle; a beat that produces
//  results stalls the input until they have all gone out (held blanks, then one
//  char or end marker where one is needed), set by the one-blank-per-cycle shift
//  of the cell chain into the output register while the output is not stalled.
//  Reset (synchronous, active low) clears the fill count, skip and overflow
//  flags, the sequencer and the output valid; the cell contents are not reset.
//  A stall on the output holds the output register and freezes the drain.

module segment_break_space_trimmer
    import sbst_pkg::*;
#(
    parameter int BLANK_BUFFER_DEPTH = 32
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    // input channel
    input  logic            i_in_valid,
    output logic            o_in_stall,
    input  logic [CP_W-1:0] i_code_point,
    input  logic            i_end_of_text,
    // output channel
    output logic            o_out_valid,
    input  logic            i_out_stall,
    output logic [CP_W-1:0] o_out_code_point,
    output logic            o_char_valid,
    output logic            o_last_of_run,
    output logic            o_text_done,
    output logic            o_blank_overflow
);

`include "assert_macros.svh"

    localparam int CNT_W = $clog2(BLANK_BUFFER_DEPTH + 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(BLANK_BUFFER_DEPTH);
    localparam logic [CNT_W-1:0] CNT_ONE  = CNT_W'(1);
    localparam logic [CNT_W-1:0] CNT_ZERO = '0;

    // ---------------------------------------------------------------------
    // control state
    // ---------------------------------------------------------------------
    t_state           r_state, n_state;
    logic [CNT_W-1:0] r_count, n_count;   // held blanks in the chain
    logic             r_skip;             // swallowing blanks after a break
    logic             r_ovf;              // blank dropped since last release

    // per-beat context kept while its results go out
    logic [CP_W-1:0]  r_tail_cp;
    logic             r_tail_char;        // tail is a char, not a bare marker
    logic             r_has_tail;
    logic             r_eot;
    logic             r_ovf_snap;

    // output register
    logic             r_out_valid;
    logic [CP_W-1:0]  r_out_cp;
    logic             r_out_char;
    logic             r_out_last;
    logic             r_out_done;
    logic             r_out_ovf;

    // ---------------------------------------------------------------------
    // input decode
    // ---------------------------------------------------------------------
    logic             in_acc;
    logic             blank;
    logic             brk;
    logic             full;
    logic             push;
    logic [CNT_W-1:0] count_after;
    logic             has_char;
    logic             need_tail;
    logic             drain;
    logic             produces;
    logic             ovf_now;
    logic             out_free;
    logic             out_load;

    assign in_acc      = i_in_valid && (r_state == S_IDLE);
    assign o_in_stall  = (r_state != S_IDLE);
    assign blank       = is_blank_cp(i_code_point);
    assign brk         = is_break_cp(i_code_point);
    assign full        = (r_count == CNT_FULL);
    assign push        = in_acc && blank && !r_skip && !full;
    // break discards the held run; a pushed blank grows it
    assign count_after = push ? (r_count + CNT_ONE) : (brk ? CNT_ZERO : r_count);
    assign has_char    = !blank;
    // bare end marker only when nothing at all comes out for this beat
    assign need_tail   = has_char || (i_end_of_text && (count_after == CNT_ZERO));
    assign drain       = (count_after != CNT_ZERO) && (has_char || i_end_of_text);
    assign produces    = has_char || i_end_of_text;
    assign ovf_now     = r_ovf || (blank && !r_skip && full);

    assign out_free    = !r_out_valid || !i_out_stall;

    // ---------------------------------------------------------------------
    // blank cell chain
    // ---------------------------------------------------------------------
    t_cell_ctl                     cell_ctl;
    logic [BLANK_BUFFER_DEPTH-1:0] cell_kind;
    logic                          drain_beat;
    logic                          tail_beat;

    assign drain_beat     = (r_state == S_DRAIN) && out_free;
    assign tail_beat      = (r_state == S_TAIL) && out_free;
    assign out_load       = drain_beat || tail_beat;

    assign cell_ctl.push  = push;
    assign cell_ctl.shift = drain_beat;
    assign cell_ctl.kind  = (i_code_point == CP_TAB) ? KIND_TAB : KIND_SPACE;

    genvar gi;
    generate
        for (gi = 0; gi < BLANK_BUFFER_DEPTH; gi++) begin : g_cell
            logic next_kind;
            if (gi == BLANK_BUFFER_DEPTH - 1) begin : g_end
                assign next_kind = KIND_SPACE;
            end else begin : g_mid
                assign next_kind = cell_kind[gi+1];
            end
            sbst_cell #(
                .CNT_W (CNT_W),
                .IDX   (gi)
            ) u_cell (
                .i_clk       (i_clk),
                .i_ctl       (cell_ctl),
                .i_count     (r_count),
                .i_next_kind (next_kind),
                .o_kind      (cell_kind[gi])
            );
        end
    endgenerate

    // ---------------------------------------------------------------------
    // sequencer
    // ---------------------------------------------------------------------
    always_comb begin
        n_state = r_state;
        n_count = r_count;
        unique case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    n_count = count_after;
                    if (drain) begin
                        n_state = S_DRAIN;
                    end else if (need_tail) begin
                        n_state = S_TAIL;
                    end
                end
            end
            S_DRAIN: begin
                if (out_free) begin
                    n_count = r_count - CNT_ONE;
                    if (r_count == CNT_ONE) begin
                        n_state = r_has_tail ? S_TAIL : S_IDLE;
                    end
                end
            end
            S_TAIL: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= CNT_ZERO;
            r_skip  <= 1'b0;
            r_ovf   <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            if (in_acc) begin
                if (i_end_of_text || has_char) begin
                    r_skip <= brk && !i_end_of_text;
                end
                r_ovf <= produces ? 1'b0 : ovf_now;
            end
        end
    end

    // beat context, no reset needed
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_tail_cp   <= brk ? CP_LF : (has_char ? i_code_point : CP_NONE);
            r_tail_char <= has_char;
            r_has_tail  <= need_tail;
            r_eot       <= i_end_of_text;
            r_ovf_snap  <= ovf_now;
        end
    end

    // ---------------------------------------------------------------------
    // output register
    // ---------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_load) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (drain_beat) begin
            r_out_cp   <= (cell_kind[0] == KIND_TAB) ? CP_TAB : CP_SPACE;
            r_out_char <= 1'b1;
            r_out_last <= (r_count == CNT_ONE) && !r_has_tail;
            r_out_done <= (r_count == CNT_ONE) && !r_has_tail && r_eot;
            r_out_ovf  <= r_ovf_snap;
        end else if (tail_beat) begin
            r_out_cp   <= r_tail_cp;
            r_out_char <= r_tail_char;
            r_out_last <= 1'b1;
            r_out_done <= r_eot;
            r_out_ovf  <= r_ovf_snap;
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_out_code_point = r_out_cp;
    assign o_char_valid     = r_out_char;
    assign o_last_of_run    = r_out_last;
    assign o_text_done      = r_out_done;
    assign o_blank_overflow = r_out_ovf;

    // ---------------------------------------------------------------------
    // assertions
    // ---------------------------------------------------------------------
    `SBST_ASSERT_ALWAYS(a_count_bound, r_count <= CNT_FULL,
        "held blank count beyond buffer depth")
    `SBST_ASSERT_IMP(a_skip_empty, r_skip, r_count == CNT_ZERO,
        "blanks held while skipping after a break")
    `SBST_ASSERT_IMP(a_drain_nonempty, r_state == S_DRAIN, r_count != CNT_ZERO,
        "drain state with an empty blank chain")
    `SBST_ASSERT_IMP(a_done_is_last, r_out_valid && r_out_done, r_out_last,
        "end of text flagged on a result that is not last of its beat")

endmodule

// ===== hdl/sbst_cell.sv =====
// One cell of the held-blank shift chain: stores the kind of one held blank.
`timescale 1ns / 1ps

module sbst_cell
    import sbst_pkg::*;
#(
    parameter int CNT_W = 6,
    parameter int IDX   = 0
) (
    input  logic             i_clk,
    input  t_cell_ctl        i_ctl,
    input  logic [CNT_W-1:0] i_count,
    input  logic             i_next_kind,
    output logic             o_kind
);

    logic r_kind;

    // shift toward cell 0 on release; append at the fill position on push
    always_ff @(posedge i_clk) begin
        if (i_ctl.shift) begin
            r_kind <= i_next_kind;
        end else if (i_ctl.push && (i_count == CNT_W'(IDX))) begin
            r_kind <= i_ctl.kind;
        end
    end

    assign o_kind = r_kind;

endmodule
